/* rtl/wdhe_pkg.sv */
// Package for the waypoint distance / heading error pipeline.
// Payload structs, mode codes and config register indexes; no dependencies.
package wdhe_pkg;

   localparam logic [1:0] CMD_ADVANCE = 2'd0;
   localparam logic [1:0] CMD_FREE    = 2'd1;
   localparam logic [1:0] CMD_TURN    = 2'd2;

   localparam logic [2:0] REG_NEAR_RADIUS  = 3'd0;
   localparam logic [2:0] REG_ADV_DIST_TOL = 3'd1;
   localparam logic [2:0] REG_FINE_ANG_TOL = 3'd2;
   localparam logic [2:0] REG_STEER_ANG    = 3'd3;
   localparam logic [2:0] REG_STEER_DIST   = 3'd4;
   localparam logic [2:0] REG_FREE_ANG_TOL = 3'd5;
   localparam logic [2:0] REG_FREE_DIST    = 3'd6;
   localparam logic [2:0] REG_TURN_DIST    = 3'd7;

   localparam int unsigned KINV_Q28 = 163008219;

   typedef struct packed {
      logic [1:0]   cmd;
      logic [15:0]  target_x;
      logic [15:0]  target_y;
      logic [15:0]  target_heading;
      logic [15:0]  robot_x;
      logic [15:0]  robot_y;
      logic [15:0]  robot_heading;
   } req_type;

   typedef struct packed {
      logic [17:0]  signed_distance;
      logic [15:0]  angle_error;
      logic         heading_reached;
      logic         distance_reached;
   } rsp_type;

   // arctangent of 2^-i, in units of 2^-32 turn
   function automatic logic [31:0] atan_turn32(input int i);
      logic [31:0] t;
      begin
         case (i % 24)
            0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
            3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
            6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
            9: t = 32'h00145F2F;  10: t = 32'h000A2F98; 11: t = 32'h000517CC;
            12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
            15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
            18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
            21: t = 32'h00000146; 22: t = 32'h000000A3; default: t = 32'h00000051;
         endcase
         return t;
      end
   endfunction

endpackage

/* rtl/wdhe_cordic_stage.sv */
// One CORDIC micro-rotation stage, shared by vectoring and rotation passes.
// Depends on wdhe_pkg for the arctangent table.
module wdhe_cordic_stage #(
   parameter int XW    = 20,
   parameter int AW    = 16,
   parameter int STAGE = 0
) (
   input  logic                 vectoring,
   input  logic signed [XW-1:0] x_in,
   input  logic signed [XW-1:0] y_in,
   input  logic [AW-1:0]        z_in,
   output logic signed [XW-1:0] x_out,
   output logic signed [XW-1:0] y_out,
   output logic [AW-1:0]        z_out
);
   import wdhe_pkg::*;

   localparam logic [32:0] HALF_LSB = (33'd1 << (32 - AW)) >> 1;
   localparam logic [32:0] STEP_W   = ({1'b0, atan_turn32(STAGE)} + HALF_LSB) >> (32 - AW);
   localparam logic [AW-1:0] STEP   = STEP_W[AW-1:0];

   logic up;

   // vectoring drives y to zero, rotation drives z to zero
   always_comb begin
      if (vectoring) begin
         up = (y_in > 0);
      end else begin
         up = ~z_in[AW-1];
      end
      if (vectoring ? up : ~up) begin
         x_out = x_in + (y_in >>> STAGE);
         y_out = y_in - (x_in >>> STAGE);
      end else begin
         x_out = x_in - (y_in >>> STAGE);
         y_out = y_in + (x_in >>> STAGE);
      end
      z_out = up ? (vectoring ? z_in + STEP : z_in - STEP)
                 : (vectoring ? z_in - STEP : z_in + STEP);
   end

endmodule

/* rtl/waypoint_distance_heading_error.sv */
// Waypoint distance / heading error: pipelined CORDIC bearing, projection and root.
// Throughput: one beat per cycle; busy is held low, the unrolled CORDIC and root
// stages each take a new beat every clock. The receiver cannot stall.
// Reset (synchronous, active high) clears valid bits and restores register defaults.
module waypoint_distance_heading_error #(
   parameter int COORD_WIDTH   = 16,
   parameter int ANGLE_WIDTH   = 16,
   parameter int CORDIC_STAGES = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  wdhe_pkg::req_type req_data,
   output logic              rsp_valid,
   output wdhe_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [15:0]       csr_data
);
   import wdhe_pkg::*;

   localparam int DW  = COORD_WIDTH + 1;          // delta width
   localparam int XW  = COORD_WIDTH + 4;          // cordic datapath with gain headroom
   localparam int AW  = ANGLE_WIDTH;
   localparam int SW  = 2 * DW;                   // squared-distance width
   localparam int RW  = DW;                       // root width
   localparam int NR  = RW;                       // root iterations
   localparam int UP16 = (AW >= 16) ? AW - 16 : 0;
   localparam int DN16 = (AW < 16) ? 16 - AW : 0;
   localparam logic [AW-1:0] AHALF = AW'(1) << (AW - 1);

   // ---------------- config registers ----------------
   logic [15:0] near_ff, adv_tol_ff, steer_dist_ff, free_dist_ff, turn_dist_ff;
   logic [14:0] fine_ang_ff, steer_ang_ff, free_ang_ff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         near_ff       <= 16'd20;
         adv_tol_ff    <= 16'd10;
         fine_ang_ff   <= 15'd328;
         steer_ang_ff  <= 15'd4096;
         steer_dist_ff <= 16'd30;
         free_ang_ff   <= 15'd2185;
         free_dist_ff  <= 16'd40;
         turn_dist_ff  <= 16'd5;
      end else if (csr_valid) begin
         case (csr_index)
            REG_NEAR_RADIUS:  near_ff       <= csr_data;
            REG_ADV_DIST_TOL: adv_tol_ff    <= csr_data;
            REG_FINE_ANG_TOL: fine_ang_ff   <= csr_data[14:0];
            REG_STEER_ANG:    steer_ang_ff  <= csr_data[14:0];
            REG_STEER_DIST:   steer_dist_ff <= csr_data;
            REG_FREE_ANG_TOL: free_ang_ff   <= csr_data[14:0];
            REG_FREE_DIST:    free_dist_ff  <= csr_data;
            REG_TURN_DIST:    turn_dist_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------- stage 0: deltas ----------------
   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] th;
      logic [15:0] rh;
   } side_type;

   logic                 v0_ff;
   side_type             s0_ff;
   logic signed [DW-1:0] dx0_ff, dy0_ff;

   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else       v0_ff <= start;
      s0_ff.cmd <= req_data.cmd;
      s0_ff.th  <= req_data.target_heading;
      s0_ff.rh  <= req_data.robot_heading;
      dx0_ff <= DW'($signed(req_data.target_x[COORD_WIDTH-1:0]))
              - DW'($signed(req_data.robot_x[COORD_WIDTH-1:0]));
      dy0_ff <= DW'($signed(req_data.target_y[COORD_WIDTH-1:0]))
              - DW'($signed(req_data.robot_y[COORD_WIDTH-1:0]));
   end

   // ---------------- stage 1: squares, cordic pre-rotation ----------------
   logic                 v1_ff;
   side_type             s1_ff;
   logic [SW-1:0]        d2_ff;
   logic                 zero1_ff;
   logic signed [XW-1:0] vx1_ff, vy1_ff, rx1_ff, ry1_ff;
   logic [AW-1:0]        vz1_ff, rz1_ff;

   logic [DW-1:0]        ax0, ay0;
   logic signed [XW-1:0] cx0, cy0;
   logic [AW-1:0]        rot0;
   logic signed [AW-1:0] rot0_s;

   always_comb begin
      ax0 = dx0_ff[DW-1] ? DW'(-dx0_ff) : dx0_ff;
      ay0 = dy0_ff[DW-1] ? DW'(-dy0_ff) : dy0_ff;
      // vector is (dy, -dx)
      cx0 = XW'(dy0_ff);
      cy0 = -XW'(dx0_ff);
      rot0 = -AW'(({s0_ff.rh, {UP16{1'b0}}}) >> DN16);
      rot0_s = rot0;
   end

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else       v1_ff <= v0_ff;
      s1_ff    <= s0_ff;
      d2_ff    <= SW'(ax0) * SW'(ax0) + SW'(ay0) * SW'(ay0);
      zero1_ff <= (dx0_ff == '0) && (dy0_ff == '0);
      if (cx0 < 0) begin
         vx1_ff <= -cx0; vy1_ff <= -cy0; vz1_ff <= AHALF;
      end else begin
         vx1_ff <= cx0;  vy1_ff <= cy0;  vz1_ff <= '0;
      end
      if (rot0_s > $signed(AW'(1) << (AW - 2)) || rot0_s < -$signed(AW'(1) << (AW - 2)))
      begin
         rx1_ff <= -cx0; ry1_ff <= -cy0; rz1_ff <= rot0 + AHALF;
      end else begin
         rx1_ff <= cx0;  ry1_ff <= cy0;  rz1_ff <= rot0;
      end
   end

   // ---------------- cordic pipelines ----------------
   logic signed [XW-1:0] vx_ff [CORDIC_STAGES+1];
   logic signed [XW-1:0] vy_ff [CORDIC_STAGES+1];
   logic [AW-1:0]        vz_ff [CORDIC_STAGES+1];
   logic signed [XW-1:0] rx_ff [CORDIC_STAGES+1];
   logic signed [XW-1:0] ry_ff [CORDIC_STAGES+1];
   logic [AW-1:0]        rz_ff [CORDIC_STAGES+1];
   logic [SW-1:0]        cd2_ff [CORDIC_STAGES+1];
   logic                 cz_ff [CORDIC_STAGES+1];
   side_type             cs_ff [CORDIC_STAGES+1];
   logic                 cv_ff [CORDIC_STAGES+1];

   assign vx_ff[0] = vx1_ff;  assign vy_ff[0] = vy1_ff;  assign vz_ff[0] = vz1_ff;
   assign rx_ff[0] = rx1_ff;  assign ry_ff[0] = ry1_ff;  assign rz_ff[0] = rz1_ff;
   assign cd2_ff[0] = d2_ff;  assign cz_ff[0] = zero1_ff;
   assign cs_ff[0] = s1_ff;   assign cv_ff[0] = v1_ff;

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      logic signed [XW-1:0] vx_in, vy_in, rx_in, ry_in;
      logic [AW-1:0]        vz_in, rz_in;

      wdhe_cordic_stage #(.XW(XW), .AW(AW), .STAGE(i)) u_vec (
         .vectoring(1'b1), .x_in(vx_ff[i]), .y_in(vy_ff[i]), .z_in(vz_ff[i]),
         .x_out(vx_in), .y_out(vy_in), .z_out(vz_in));
      wdhe_cordic_stage #(.XW(XW), .AW(AW), .STAGE(i)) u_rot (
         .vectoring(1'b0), .x_in(rx_ff[i]), .y_in(ry_ff[i]), .z_in(rz_ff[i]),
         .x_out(rx_in), .y_out(ry_in), .z_out(rz_in));

      always_ff @(posedge clock) begin
         if (reset) cv_ff[i+1] <= 1'b0;
         else       cv_ff[i+1] <= cv_ff[i];
         vx_ff[i+1]  <= vx_in;  vy_ff[i+1] <= vy_in;  vz_ff[i+1] <= vz_in;
         rx_ff[i+1]  <= rx_in;  ry_ff[i+1] <= ry_in;  rz_ff[i+1] <= rz_in;
         cd2_ff[i+1] <= cd2_ff[i];
         cz_ff[i+1]  <= cz_ff[i];
         cs_ff[i+1]  <= cs_ff[i];
      end
   end

   // ---------------- stage: bearing, projection multiply ----------------
   logic                 v2_ff;
   side_type             s2_ff;
   logic [SW-1:0]        d2b_ff;
   logic [15:0]          bear2_ff;
   logic signed [XW+29:0] pm2_ff;

   logic [AW-1:0] bz;
   logic [AW:0]   bsum;
   logic [15:0]   bear_c;

   always_comb begin
      bz     = cz_ff[CORDIC_STAGES] ? '0 : vz_ff[CORDIC_STAGES];
      bsum   = {1'b0, bz} + ((AW+1)'(1) << UP16 >> 1);
      bear_c = 16'(bsum[AW-1:0] >> UP16) << DN16;
   end

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else       v2_ff <= cv_ff[CORDIC_STAGES];
      s2_ff    <= cs_ff[CORDIC_STAGES];
      d2b_ff   <= cd2_ff[CORDIC_STAGES];
      bear2_ff <= bear_c;
      pm2_ff   <= (XW+30)'(rx_ff[CORDIC_STAGES]) * $signed({1'b0, 29'(KINV_Q28)});
   end

   // ---------------- stage: projection round, root setup ----------------
   logic                 v3_ff;
   side_type             s3_ff;
   logic [15:0]          tb3_ff;
   logic signed [XW+1:0] proj3_ff;
   logic [SW-1:0]        d2c_ff;

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else       v3_ff <= v2_ff;
      s3_ff    <= s2_ff;
      d2c_ff   <= d2b_ff;
      tb3_ff   <= bear2_ff - s2_ff.rh;
      proj3_ff <= (XW+2)'((pm2_ff + (XW+30)'(1 <<< 27)) >>> 28);
   end

   // ---------------- integer root: one result bit per stage ----------------
   logic [SW-1:0]        qrem_ff [NR+1];
   logic [RW-1:0]        qroot_ff [NR+1];
   logic [SW-1:0]        qd2_ff [NR+1];
   logic signed [XW+1:0] qproj_ff [NR+1];
   logic [15:0]          qtb_ff [NR+1];
   side_type             qs_ff [NR+1];
   logic                 qv_ff [NR+1];

   assign qrem_ff[0] = d2c_ff;   assign qroot_ff[0] = '0;
   assign qd2_ff[0] = d2c_ff;    assign qproj_ff[0] = proj3_ff;
   assign qtb_ff[0] = tb3_ff;    assign qs_ff[0] = s3_ff;   assign qv_ff[0] = v3_ff;

   for (genvar k = 0; k < NR; k++) begin : g_root
      localparam int B = NR - 1 - k;
      logic [SW+1:0] trial;
      logic [RW-1:0] cand;
      // (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B); remainder tracks d2 - r^2
      always_comb begin
         cand  = qroot_ff[k] | (RW'(1) << B);
         trial = ((SW+2)'(qroot_ff[k]) << (B + 1)) + ((SW+2)'(1) << (2 * B));
      end
      always_ff @(posedge clock) begin
         if (reset) qv_ff[k+1] <= 1'b0;
         else       qv_ff[k+1] <= qv_ff[k];
         if ({2'b00, qrem_ff[k]} >= trial) begin
            qroot_ff[k+1] <= cand;
            qrem_ff[k+1]  <= SW'({2'b00, qrem_ff[k]} - trial);
         end else begin
            qroot_ff[k+1] <= qroot_ff[k];
            qrem_ff[k+1]  <= qrem_ff[k];
         end
         qd2_ff[k+1]   <= qd2_ff[k];
         qproj_ff[k+1] <= qproj_ff[k];
         qtb_ff[k+1]   <= qtb_ff[k];
         qs_ff[k+1]    <= qs_ff[k];
      end
   end

   // ---------------- final stage: mode rules ----------------
   logic                 v4_ff;
   rsp_type              r4_ff;

   logic signed [XW+2:0] dist_c, dabs;
   logic [15:0]          err, hd;
   logic signed [16:0]   es;
   logic [16:0]          eabs;
   logic                 hr, dr, near;
   logic signed [XW+1:0] pj;
   logic [RW-1:0]        rt;
   logic [17:0]          dsat;

   always_comb begin
      pj   = qproj_ff[NR];
      rt   = qroot_ff[NR];
      hd   = qs_ff[NR].th - qs_ff[NR].rh;
      near = (qd2_ff[NR] < SW'({16'd0, near_ff} * {16'd0, near_ff}));
      dist_c = '0;
      err  = '0;
      hr   = 1'b0;
      dr   = 1'b0;
      case (qs_ff[NR].cmd)
         CMD_ADVANCE: begin
            if (near) begin
               dist_c = (XW+3)'(pj);
               err  = hd;
            end else begin
               dist_c = pj < 0 ? -(XW+3)'({1'b0, rt}) : (XW+3)'({1'b0, rt});
               err  = qtb_ff[NR];
            end
         end
         CMD_FREE: begin
            dist_c = (XW+3)'(pj);
            err  = pj > 0 ? qtb_ff[NR] : qtb_ff[NR] + 16'h8000;
         end
         CMD_TURN: begin
            dist_c = (XW+3)'(pj);
            err  = hd;
         end
         default: ;
      endcase
      es   = 17'($signed(err));
      eabs = es < 0 ? 17'(-es) : 17'(es);
      dabs = dist_c < 0 ? -dist_c : dist_c;
      case (qs_ff[NR].cmd)
         CMD_ADVANCE: begin
            hr = eabs < {2'd0, fine_ang_ff};
            dr = (dabs < (XW+3)'(adv_tol_ff))
               || ((eabs > {2'd0, steer_ang_ff})
                   && (dist_c > $signed((XW+3)'(steer_dist_ff))));
         end
         CMD_FREE: begin
            hr = eabs < {2'd0, free_ang_ff};
            dr = dabs < (XW+3)'(free_dist_ff);
         end
         CMD_TURN: begin
            hr = eabs < {2'd0, fine_ang_ff};
            dr = hr || (dabs < (XW+3)'(turn_dist_ff));
         end
         default: ;
      endcase
      if (dist_c > (XW+3)'(131071))       dsat = 18'h1FFFF;
      else if (dist_c < -(XW+3)'(131072)) dsat = 18'h20000;
      else                                 dsat = dist_c[17:0];
   end

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else       v4_ff <= qv_ff[NR];
      r4_ff.signed_distance  <= dsat;
      r4_ff.angle_error      <= err;
      r4_ff.heading_reached  <= hr;
      r4_ff.distance_reached <= dr;
   end

   assign rsp_valid = v4_ff;
   assign rsp_data  = r4_ff;

   // ---------------- checks ----------------
   a_valid_pipe: assert property (@(posedge clock) disable iff (reset)
      v1_ff |-> $past(v0_ff)) else $error("valid bit lost in stage 1");
   a_turn_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.heading_reached && $past(qs_ff[NR].cmd) == CMD_TURN
      |-> rsp_data.distance_reached) else $error("turn arrival flags disagree");
   a_reserved_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(qs_ff[NR].cmd) != CMD_ADVANCE && $past(qs_ff[NR].cmd) != CMD_FREE
      && $past(qs_ff[NR].cmd) != CMD_TURN |-> rsp_data == '0)
      else $error("reserved mode gave nonzero result");

endmodule

/* tb/waypoint_distance_heading_error_test.sv */
// Self-checking testbench for waypoint_distance_heading_error: random and directed poses,
// checked against an in-bench fixed-point predictor. Depends on rtl/wdhe_pkg.sv and the RTL.
module waypoint_distance_heading_error_test;
   timeunit 1ns;
   timeprecision 1ps;
   import wdhe_pkg::*;

   localparam int PIPE_DELAY = 16 + 16 + 6;
   localparam logic [15:0] STEP_ANGLE [16] = '{
      16'h2000, 16'h12E4, 16'h09FB, 16'h0511, 16'h028B, 16'h0146, 16'h00A3, 16'h0051,
      16'h0029, 16'h0014, 16'h000A, 16'h0005, 16'h0003, 16'h0001, 16'h0001, 16'h0000};

   logic clock = 0, reset = 1, start = 0, busy;
   logic csr_valid = 0, csr_ready;
   logic [2:0] csr_index = '0;
   logic [15:0] csr_data = '0;
   req_type req_data = '0;
   logic rsp_valid;
   rsp_type rsp_data;

   logic [15:0] csr_shadow [8];
   rsp_type expected_rsp [$];
   int errors = 0;
   bit burst_mode = 0;

   waypoint_distance_heading_error u_top (.*);

   initial forever #5 clock = ~clock;

   initial begin
      #20ms;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic longint root_floor(longint v);
      longint r, b;
      r = 0;
      b = longint'(1) << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint mag(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic rsp_type predict_guidance(req_type r);
      longint dx, dy, d2, d, x, y, nx, ny, proj, dist_v, nr;
      logic [15:0] z, bear, tb, hd, err;
      logic hr, dr;
      rsp_type o;
      dx = longint'($signed(r.target_x)) - longint'($signed(r.robot_x));
      dy = longint'($signed(r.target_y)) - longint'($signed(r.robot_y));
      d2 = dx * dx + dy * dy;
      d = root_floor(d2);
      // bearing: vectoring pass on (dy, -dx)
      x = dy; y = -dx; z = '0;
      if (x != 0 || y != 0) begin
         if (x < 0) begin
            x = -x; y = -y; z = 16'h8000;
         end
         for (int i = 0; i < 16; i++) begin
            if (y > 0) begin
               nx = x + (y >>> i); ny = y - (x >>> i); z = z + STEP_ANGLE[i];
            end else begin
               nx = x - (y >>> i); ny = y + (x >>> i); z = z - STEP_ANGLE[i];
            end
            x = nx; y = ny;
         end
      end
      bear = z;
      // projection: rotate (dy, -dx) by -robot_heading
      x = dy; y = -dx; z = -r.robot_heading;
      if ($signed(z) > 16384 || $signed(z) < -16384) begin
         x = -x; y = -y; z = z + 16'h8000;
      end
      for (int i = 0; i < 16; i++) begin
         if (!z[15]) begin
            nx = x - (y >>> i); ny = y + (x >>> i); z = z - STEP_ANGLE[i];
         end else begin
            nx = x + (y >>> i); ny = y - (x >>> i); z = z + STEP_ANGLE[i];
         end
         x = nx; y = ny;
      end
      proj = (x * longint'(KINV_Q28) + (longint'(1) << 27)) >>> 28;
      tb = bear - r.robot_heading;
      hd = r.target_heading - r.robot_heading;
      dist_v = 0; err = '0; hr = 0; dr = 0;
      case (r.cmd)
         CMD_ADVANCE: begin
            nr = longint'(csr_shadow[REG_NEAR_RADIUS]);
            if (d2 < nr * nr) begin
               dist_v = proj; err = hd;
            end else begin
               dist_v = proj < 0 ? -d : d; err = tb;
            end
            hr = mag($signed(err)) < csr_shadow[REG_FINE_ANG_TOL];
            if (mag(dist_v) < csr_shadow[REG_ADV_DIST_TOL]) dr = 1;
            else dr = mag($signed(err)) > csr_shadow[REG_STEER_ANG]
                      && dist_v > longint'(csr_shadow[REG_STEER_DIST]);
         end
         CMD_FREE: begin
            dist_v = proj;
            err = proj > 0 ? tb : tb + 16'h8000;
            hr = mag($signed(err)) < csr_shadow[REG_FREE_ANG_TOL];
            dr = mag(dist_v) < csr_shadow[REG_FREE_DIST];
         end
         CMD_TURN: begin
            dist_v = proj; err = hd;
            dr = mag(dist_v) < csr_shadow[REG_TURN_DIST];
            if (mag($signed(err)) < csr_shadow[REG_FINE_ANG_TOL]) begin
               hr = 1; dr = 1;
            end
         end
         default: ;
      endcase
      if (dist_v > 131071) dist_v = 131071;
      if (dist_v < -131072) dist_v = -131072;
      o.signed_distance = dist_v[17:0];
      o.angle_error = err;
      o.heading_reached = hr;
      o.distance_reached = dr;
      return o;
   endfunction

   // result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_rsp.size() == 0) begin
            $error("unexpected result beat %p", rsp_data);
            errors++;
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_data.signed_distance !== want.signed_distance) begin
               $error("signed_distance exp %0d got %0d", $signed(want.signed_distance),
                      $signed(rsp_data.signed_distance));
               errors++;
            end
            if (rsp_data.angle_error !== want.angle_error) begin
               $error("angle_error exp %0d got %0d", $signed(want.angle_error),
                      $signed(rsp_data.angle_error));
               errors++;
            end
            if (rsp_data.heading_reached !== want.heading_reached) begin
               $error("heading_reached exp %0b got %0b", want.heading_reached,
                      rsp_data.heading_reached);
               errors++;
            end
            if (rsp_data.distance_reached !== want.distance_reached) begin
               $error("distance_reached exp %0b got %0b", want.distance_reached,
                      rsp_data.distance_reached);
               errors++;
            end
         end
      end
   end

   task automatic send_pose(req_type r);
      int gap;
      @(negedge clock);
      req_data <= r;
      start <= 1;
      do @(posedge clock); while (busy);
      expected_rsp.push_back(predict_guidance(r));
      if ($urandom_range(0, 49) == 0) burst_mode = !burst_mode;
      gap = burst_mode ? 0 : int'($urandom_range(0, 18));
      if (gap > 0) begin
         @(negedge clock);
         start <= 0;
         repeat (gap - 1) @(posedge clock);
      end
   endtask

   task automatic drain;
      @(negedge clock);
      start <= 0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (PIPE_DELAY + 3) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_shadow[idx] = (idx == REG_FINE_ANG_TOL || idx == REG_STEER_ANG
                         || idx == REG_FREE_ANG_TOL) ? {1'b0, val[14:0]} : val;
      @(negedge clock);
      csr_valid <= 0;
   endtask

   function automatic logic [15:0] clamp16(int v);
      if (v > 32767) return 16'sd32767;
      if (v < -32768) return 16'h8000;
      return v[15:0];
   endfunction

   function automatic req_type random_pose();
      req_type r;
      int k;
      r.cmd = ($urandom_range(0, 39) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      r.robot_x = 16'($urandom); r.robot_y = 16'($urandom);
      r.robot_heading = 16'($urandom); r.target_heading = 16'($urandom);
      k = int'($urandom_range(0, 9));
      if (k < 4) begin
         // close to the target: exercises the tolerance thresholds
         r.target_x = clamp16(int'($signed(r.robot_x)) + int'($urandom_range(0, 120)) - 60);
         r.target_y = clamp16(int'($signed(r.robot_y)) + int'($urandom_range(0, 120)) - 60);
         if ($urandom_range(0, 1)) r.target_heading = r.robot_heading
                                                    + 16'($urandom_range(0, 1200) - 600);
      end else if (k < 7) begin
         r.target_x = clamp16(int'($signed(r.robot_x)) + int'($urandom_range(0, 2000)) - 1000);
         r.target_y = clamp16(int'($signed(r.robot_y)) + int'($urandom_range(0, 2000)) - 1000);
      end else begin
         r.target_x = 16'($urandom); r.target_y = 16'($urandom);
      end
      return r;
   endfunction

   task automatic test_directed;
      req_type r;
      for (int c = 0; c < 4; c++) begin
         r = '{cmd: 2'(c), target_x: 16'h7FFF, target_y: 16'h7FFF, target_heading: 16'h8000,
               robot_x: 16'h8000, robot_y: 16'h8000, robot_heading: 16'h7FFF};
         send_pose(r);
         r = '{cmd: 2'(c), target_x: 16'h8000, target_y: 16'h7FFF, target_heading: 16'h0000,
               robot_x: 16'h7FFF, robot_y: 16'h8000, robot_heading: 16'h8000};
         send_pose(r);
         // target on robot
         r = '{cmd: 2'(c), target_x: 16'h1234, target_y: 16'hFEDC, target_heading: 16'h0100,
               robot_x: 16'h1234, robot_y: 16'hFEDC, robot_heading: 16'h0000};
         send_pose(r);
         r = '{cmd: 2'(c), target_x: 16'd3, target_y: 16'd100, target_heading: 16'h4000,
               robot_x: 16'd0, robot_y: 16'd0, robot_heading: 16'hC000};
         send_pose(r);
         r = '{cmd: 2'(c), target_x: 16'd0, target_y: 16'hFF00, target_heading: 16'hFFFF,
               robot_x: 16'd0, robot_y: 16'd0, robot_heading: 16'h0000};
         send_pose(r);
      end
      drain();
   endtask

   task automatic test_random(int count);
      repeat (count) send_pose(random_pose());
      drain();
   endtask

   task automatic test_config_random;
      for (int i = 0; i < 8; i++) write_reg(3'(i), 16'($urandom_range(0, 400)));
      test_random(250);
   endtask

   task automatic test_config_extremes;
      for (int i = 0; i < 8; i++) write_reg(3'(i), 16'h0000);
      test_random(100);
      for (int i = 0; i < 8; i++) write_reg(3'(i), 16'hFFFF);
      test_random(100);
      for (int i = 0; i < 8; i++) write_reg(3'(i), 16'($urandom));
      test_random(100);
   endtask

   initial begin
      csr_shadow = '{16'd20, 16'd10, 16'd328, 16'd4096, 16'd30, 16'd2185, 16'd40, 16'd5};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      test_directed();
      test_random(330);
      test_config_random();
      test_config_extremes();
      if (errors == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end
endmodule
